// File: rtl/core/s3f_pkg.sv
package s3f_pkg;

    // Fixed field widths of the item and result.
    localparam int KEY_W = 64;
    localparam int CAP_W = 7;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Division by ten as a reciprocal multiply, exact for 7-bit values.
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    // Operation codes.
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_TOUCH  = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_EVICT  = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_ALREADY  = 3'd1,
        ST_NOT_RES  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NO_EVICT = 3'd4
    } status_t;

    // Source of the in_main result bit.
    typedef enum logic [1:0] {
        INM_NONE  = 2'd0,
        INM_ENTRY = 2'd1,
        INM_GHOST = 2'd2
    } inm_sel_t;

    // Logical offset used to address a queue.
    typedef enum logic [1:0] {
        QOFF_HEAD = 2'd0,
        QOFF_IDX  = 2'd1,
        QOFF_NEXT = 2'd2
    } qoff_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     scan_clr;
        logic     scan_inc;
        logic     ek_rd_scan;
        logic     lk_cmp;
        logic     ins_commit;
        logic     set_visited;
        logic     rm_clear;
        logic     sel_entry;
        logic     sel_small;
        logic     sel_main;
        logic     q_rd;
        qoff_t    q_off;
        logic     q_wr_shift;
        logic     q_dec;
        logic     g_rd;
        logic     g_cmp;
        logic     g_pop;
        logic     g_push;
        logic     ev_step;
        logic     ek_rd_victim;
        logic     victim_load;
        logic     done;
        status_t  res_status;
        inm_sel_t res_inm;
        logic     res_victim;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic free_found;
        logic scan_last;
        logic lk_match;
        logic g_scan_end;
        logic q_scan_end;
        logic q_match;
        logic q_shift_end;
        logic ev_found;
        logic s_empty;
        logic m_empty;
        logic small_pick;
        logic sel_is_main;
        logic g_trim;
    } sts_t;

endpackage

// File: rtl/core/s3f_ctrl.sv
module s3f_ctrl
    import s3f_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] operation,
    input  sts_t       sts,
    output logic       busy,
    output cmd_t       cmd
);

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_LK_RD    = 17'h00002,
        S_LK_CMP   = 17'h00004,
        S_DISPATCH = 17'h00008,
        S_GE_RD    = 17'h00010,
        S_GE_CMP   = 17'h00020,
        S_INS_WR   = 17'h00040,
        S_RQ_RD    = 17'h00080,
        S_RQ_CMP   = 17'h00100,
        S_SH_RD    = 17'h00200,
        S_SH_WR    = 17'h00400,
        S_EV_START = 17'h00800,
        S_EV_RD    = 17'h01000,
        S_EV_STEP  = 17'h02000,
        S_EV_KEY   = 17'h04000,
        S_EV_LOAD  = 17'h08000,
        S_GP_TRIM  = 17'h10000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] op_reg, op_next;

    // State and operation registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = operation;
                    cmd.load = 1'b1;
                    if (operation inside {OP_INSERT, OP_TOUCH, OP_REMOVE, OP_QUERY})
                    begin
                        state_next = S_LK_RD;
                    end
                    else if (operation == OP_EVICT)
                    begin
                        state_next = S_EV_START;
                    end
                    else
                    begin
                        cmd.done       = 1'b1;
                        cmd.res_status = ST_DONE;
                    end
                end
            end
            S_LK_RD:
            begin
                cmd.ek_rd_scan = 1'b1;
                state_next     = S_LK_CMP;
            end
            S_LK_CMP:
            begin
                cmd.lk_cmp = 1'b1;
                if (sts.lk_match || sts.scan_last)
                begin
                    state_next = S_DISPATCH;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_LK_RD;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (sts.hit)
                        begin
                            cmd.set_visited = 1'b1;
                            cmd.done        = 1'b1;
                            cmd.res_status  = ST_ALREADY;
                            cmd.res_inm     = INM_ENTRY;
                            state_next      = S_IDLE;
                        end
                        else if (!sts.free_found)
                        begin
                            cmd.done       = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_GE_RD;
                        end
                    end
                    OP_TOUCH, OP_QUERY:
                    begin
                        cmd.done   = 1'b1;
                        state_next = S_IDLE;
                        if (sts.hit)
                        begin
                            cmd.set_visited = (op_reg == OP_TOUCH);
                            cmd.res_status  = ST_DONE;
                            cmd.res_inm     = INM_ENTRY;
                        end
                        else
                        begin
                            cmd.res_status = ST_NOT_RES;
                        end
                    end
                    OP_REMOVE:
                    begin
                        cmd.scan_clr = 1'b1;
                        if (sts.hit)
                        begin
                            cmd.sel_entry = 1'b1;
                            state_next    = S_RQ_RD;
                        end
                        else
                        begin
                            state_next = S_GE_RD;
                        end
                    end
                    default:
                    begin
                        cmd.done       = 1'b1;
                        cmd.res_status = ST_DONE;
                        state_next     = S_IDLE;
                    end
                endcase
            end
            // Walk the ghost history and erase every copy of the key.
            S_GE_RD:
            begin
                if (sts.g_scan_end)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            state_next = S_INS_WR;
                        end
                        OP_REMOVE:
                        begin
                            cmd.done       = 1'b1;
                            cmd.res_status = sts.hit ? ST_DONE : ST_NOT_RES;
                            state_next     = S_IDLE;
                        end
                        OP_EVICT:
                        begin
                            state_next = S_GP_TRIM;
                        end
                        default:
                        begin
                            cmd.done       = 1'b1;
                            cmd.res_status = ST_DONE;
                            state_next     = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    cmd.g_rd   = 1'b1;
                    state_next = S_GE_CMP;
                end
            end
            S_GE_CMP:
            begin
                cmd.g_cmp    = 1'b1;
                cmd.scan_inc = 1'b1;
                state_next   = S_GE_RD;
            end
            S_INS_WR:
            begin
                cmd.ins_commit = 1'b1;
                cmd.done       = 1'b1;
                cmd.res_status = ST_DONE;
                cmd.res_inm    = INM_GHOST;
                state_next     = S_IDLE;
            end
            // Find the removed slot in its queue.
            S_RQ_RD:
            begin
                if (sts.q_scan_end)
                begin
                    cmd.rm_clear = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_GE_RD;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    cmd.q_off  = QOFF_IDX;
                    state_next = S_RQ_CMP;
                end
            end
            S_RQ_CMP:
            begin
                if (sts.q_match)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_RQ_RD;
                end
            end
            // Close the gap by moving later slots one place forward.
            S_SH_RD:
            begin
                if (sts.q_shift_end)
                begin
                    cmd.q_dec    = 1'b1;
                    cmd.rm_clear = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_GE_RD;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    cmd.q_off  = QOFF_NEXT;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.q_wr_shift = 1'b1;
                cmd.scan_inc   = 1'b1;
                state_next     = S_SH_RD;
            end
            // Choose the queue to drain.
            S_EV_START:
            begin
                if (sts.s_empty && sts.m_empty)
                begin
                    cmd.done       = 1'b1;
                    cmd.res_status = ST_NO_EVICT;
                    state_next     = S_IDLE;
                end
                else if (sts.small_pick)
                begin
                    cmd.sel_small = 1'b1;
                    state_next    = S_EV_RD;
                end
                else
                begin
                    cmd.sel_main = 1'b1;
                    state_next   = S_EV_RD;
                end
            end
            S_EV_RD:
            begin
                if (!sts.sel_is_main && sts.s_empty)
                begin
                    cmd.sel_main = 1'b1;
                end
                else if (sts.sel_is_main && sts.m_empty)
                begin
                    cmd.done       = 1'b1;
                    cmd.res_status = ST_NO_EVICT;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    cmd.q_off  = QOFF_HEAD;
                    state_next = S_EV_STEP;
                end
            end
            S_EV_STEP:
            begin
                cmd.ev_step = 1'b1;
                state_next  = sts.ev_found ? S_EV_KEY : S_EV_RD;
            end
            S_EV_KEY:
            begin
                cmd.ek_rd_victim = 1'b1;
                state_next       = S_EV_LOAD;
            end
            S_EV_LOAD:
            begin
                cmd.victim_load = 1'b1;
                if (sts.sel_is_main)
                begin
                    cmd.done       = 1'b1;
                    cmd.res_status = ST_DONE;
                    cmd.res_victim = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_GE_RD;
                end
            end
            // Age out old ghost entries, then append the victim.
            S_GP_TRIM:
            begin
                if (sts.g_trim)
                begin
                    cmd.g_pop = 1'b1;
                end
                else
                begin
                    cmd.g_push     = 1'b1;
                    cmd.done       = 1'b1;
                    cmd.res_status = ST_DONE;
                    cmd.res_victim = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/s3f_dp.sv
module s3f_dp
    import s3f_pkg::*;
#(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] key,
    input  logic             cap_we,
    input  logic [CAP_W-1:0] cap_wdata,
    input  cmd_t             cmd,
    output sts_t             sts,
    output logic             done,
    output logic [2:0]       status,
    output logic [KEY_W-1:0] evicted_key,
    output logic             in_main
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [CW:0]     ENT_SUM = (CW+1)'(ENTRIES);
    localparam logic [CMPW-1:0] ENT_CMP = CMPW'(ENTRIES);

    // Circular buffer address: base plus offset, wrapped at the depth.
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= ENT_SUM)
        begin
            sum = sum - ENT_SUM;
        end
        return sum[IW-1:0];
    endfunction

    // Memories.
    logic [KEY_BITS-1:0] ek_mem [ENTRIES];
    logic [KEY_BITS-1:0] g_mem  [ENTRIES];
    logic [IW-1:0]       sq_mem [ENTRIES];
    logic [IW-1:0]       mq_mem [ENTRIES];

    // Payload registers.
    logic [KEY_BITS-1:0] ek_rdata_reg;
    logic [KEY_BITS-1:0] g_rdata_reg;
    logic [IW-1:0]       sq_rdata_reg;
    logic [IW-1:0]       mq_rdata_reg;
    logic [KEY_BITS-1:0] cmp_key_reg;
    logic [IW-1:0]       hit_idx_reg;
    logic [IW-1:0]       free_idx_reg;
    logic [IW-1:0]       victim_slot_reg;
    logic [2:0]          status_reg;
    logic [KEY_W-1:0]    evk_reg;
    logic                inm_out_reg;

    // Control registers.
    logic [CAP_W-1:0]   cap_reg;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic               free_reg, free_next;
    logic               ghost_hit_reg, ghost_hit_next;
    logic               sel_main_reg, sel_main_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] inm_reg, inm_next;
    logic [ENTRIES-1:0] vis_reg, vis_next;
    logic [ENTRIES-1:0] gvalid_reg, gvalid_next;
    logic [IW-1:0]      sq_head_reg, sq_head_next;
    logic [IW-1:0]      mq_head_reg, mq_head_next;
    logic [IW-1:0]      g_head_reg, g_head_next;
    logic [CW-1:0]      sq_cnt_reg, sq_cnt_next;
    logic [CW-1:0]      mq_cnt_reg, mq_cnt_next;
    logic [CW-1:0]      g_cnt_reg, g_cnt_next;
    logic               done_reg;

    logic [IW-1:0]        idx_i;
    logic [IW-1:0]        q_rdata;
    logic [CW-1:0]        sel_cnt;
    logic [CW-1:0]        q_off;
    logic [CW:0]          idx_plus;
    logic [IW-1:0]        sq_raddr, mq_raddr;
    logic [IW-1:0]        sq_tail, mq_tail, sq_at_idx, mq_at_idx;
    logic [IW-1:0]        g_addr, g_tail;
    logic                 s_vis;
    logic                 lk_match;
    logic                 ins_small, ins_main;
    logic                 sq_we, mq_we;
    logic [IW-1:0]        sq_waddr, mq_waddr, sq_wdata, mq_wdata;
    logic                 ek_re;
    logic [IW-1:0]        ek_raddr;
    logic [CAP_W+7:0]     div_prod;
    logic [CMPW-1:0]      thr, glen;
    logic                 small_ge;

    assign idx_i    = idx_reg[IW-1:0];
    assign idx_plus = (CW+1)'(idx_reg) + (CW+1)'(1);
    assign q_rdata  = sel_main_reg ? mq_rdata_reg : sq_rdata_reg;
    assign sel_cnt  = sel_main_reg ? mq_cnt_reg : sq_cnt_reg;
    assign s_vis    = vis_reg[q_rdata];
    assign lk_match = valid_reg[idx_i] && (ek_rdata_reg == cmp_key_reg);

    // Queue addressing.
    always_comb
    begin
        case (cmd.q_off)
            QOFF_IDX:  q_off = idx_reg;
            QOFF_NEXT: q_off = idx_plus[CW-1:0];
            default:   q_off = '0;
        endcase
    end

    assign sq_raddr  = wrap_add(sq_head_reg, q_off);
    assign mq_raddr  = wrap_add(mq_head_reg, q_off);
    assign sq_tail   = wrap_add(sq_head_reg, sq_cnt_reg);
    assign mq_tail   = wrap_add(mq_head_reg, mq_cnt_reg);
    assign sq_at_idx = wrap_add(sq_head_reg, idx_reg);
    assign mq_at_idx = wrap_add(mq_head_reg, idx_reg);
    assign g_addr    = wrap_add(g_head_reg, idx_reg);
    assign g_tail    = wrap_add(g_head_reg, g_cnt_reg);

    assign ins_small = cmd.ins_commit && !ghost_hit_reg;
    assign ins_main  = cmd.ins_commit && ghost_hit_reg;

    // Queue write ports.
    always_comb
    begin
        sq_we    = 1'b0;
        sq_waddr = sq_tail;
        sq_wdata = free_idx_reg;
        if (ins_small)
        begin
            sq_we = 1'b1;
        end
        else if (cmd.q_wr_shift && !sel_main_reg)
        begin
            sq_we    = 1'b1;
            sq_waddr = sq_at_idx;
            sq_wdata = q_rdata;
        end

        mq_we    = 1'b0;
        mq_waddr = mq_tail;
        mq_wdata = free_idx_reg;
        if (ins_main)
        begin
            mq_we = 1'b1;
        end
        else if (cmd.q_wr_shift && sel_main_reg)
        begin
            mq_we    = 1'b1;
            mq_waddr = mq_at_idx;
            mq_wdata = q_rdata;
        end
        else if (cmd.ev_step && s_vis)
        begin
            mq_we    = 1'b1;
            mq_wdata = q_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_we)
        begin
            sq_mem[sq_waddr] <= sq_wdata;
        end
        if (mq_we)
        begin
            mq_mem[mq_waddr] <= mq_wdata;
        end
        if (cmd.q_rd)
        begin
            sq_rdata_reg <= sq_mem[sq_raddr];
            mq_rdata_reg <= mq_mem[mq_raddr];
        end
    end

    // Entry key memory.
    assign ek_re    = cmd.ek_rd_scan || cmd.ek_rd_victim;
    assign ek_raddr = cmd.ek_rd_victim ? victim_slot_reg : idx_i;

    always_ff @(posedge clk)
    begin
        if (cmd.ins_commit)
        begin
            ek_mem[free_idx_reg] <= cmp_key_reg;
        end
        if (ek_re)
        begin
            ek_rdata_reg <= ek_mem[ek_raddr];
        end
    end

    // Ghost key memory.
    always_ff @(posedge clk)
    begin
        if (cmd.g_push)
        begin
            g_mem[g_tail] <= cmp_key_reg;
        end
        if (cmd.g_rd)
        begin
            g_rdata_reg <= g_mem[g_addr];
        end
    end

    // Payload registers of the current item.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmp_key_reg <= key[KEY_BITS-1:0];
        end
        else if (cmd.victim_load)
        begin
            cmp_key_reg <= ek_rdata_reg;
        end
        if (cmd.lk_cmp && lk_match)
        begin
            hit_idx_reg <= idx_i;
        end
        if (cmd.lk_cmp && !valid_reg[idx_i] && !free_reg)
        begin
            free_idx_reg <= idx_i;
        end
        if (cmd.ev_step && !s_vis)
        begin
            victim_slot_reg <= q_rdata;
        end
        if (cmd.done)
        begin
            status_reg <= cmd.res_status;
            evk_reg    <= cmd.res_victim ? KEY_W'(ek_rdata_reg) : '0;
            case (cmd.res_inm)
                INM_ENTRY: inm_out_reg <= inm_reg[hit_idx_reg];
                INM_GHOST: inm_out_reg <= ghost_hit_reg;
                default:   inm_out_reg <= 1'b0;
            endcase
        end
    end

    // Next values of control state.
    always_comb
    begin
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        ghost_hit_next = ghost_hit_reg;
        sel_main_next  = sel_main_reg;
        valid_next     = valid_reg;
        inm_next       = inm_reg;
        vis_next       = vis_reg;
        gvalid_next    = gvalid_reg;
        sq_head_next   = sq_head_reg;
        mq_head_next   = mq_head_reg;
        g_head_next    = g_head_reg;
        sq_cnt_next    = sq_cnt_reg;
        mq_cnt_next    = mq_cnt_reg;
        g_cnt_next     = g_cnt_reg;

        if (cmd.load)
        begin
            idx_next       = '0;
            hit_next       = 1'b0;
            free_next      = 1'b0;
            ghost_hit_next = 1'b0;
        end
        if (cmd.scan_clr)
        begin
            idx_next = '0;
        end
        if (cmd.scan_inc)
        begin
            idx_next = idx_plus[CW-1:0];
        end

        // Lookup compare.
        if (cmd.lk_cmp)
        begin
            if (lk_match)
            begin
                hit_next = 1'b1;
            end
            if (!valid_reg[idx_i])
            begin
                free_next = 1'b1;
            end
        end

        // Queue selection.
        if (cmd.sel_entry)
        begin
            sel_main_next = inm_reg[hit_idx_reg];
        end
        if (cmd.sel_small)
        begin
            sel_main_next = 1'b0;
        end
        if (cmd.sel_main)
        begin
            sel_main_next = 1'b1;
        end

        // New entry.
        if (cmd.ins_commit)
        begin
            valid_next[free_idx_reg] = 1'b1;
            vis_next[free_idx_reg]   = 1'b0;
            inm_next[free_idx_reg]   = ghost_hit_reg;
        end
        if (ins_small)
        begin
            sq_cnt_next = sq_cnt_reg + CW'(1);
        end
        if (ins_main)
        begin
            mq_cnt_next = mq_cnt_reg + CW'(1);
        end

        if (cmd.set_visited)
        begin
            vis_next[hit_idx_reg] = 1'b1;
        end
        if (cmd.rm_clear)
        begin
            valid_next[hit_idx_reg] = 1'b0;
            inm_next[hit_idx_reg]   = 1'b0;
            vis_next[hit_idx_reg]   = 1'b0;
        end
        if (cmd.q_dec)
        begin
            if (sel_main_reg)
            begin
                mq_cnt_next = mq_cnt_reg - CW'(1);
            end
            else
            begin
                sq_cnt_next = sq_cnt_reg - CW'(1);
            end
        end

        // Eviction step: pop the head, then second chance or victim.
        if (cmd.ev_step)
        begin
            if (sel_main_reg)
            begin
                mq_head_next = wrap_add(mq_head_reg, CW'(1));
                mq_cnt_next  = s_vis ? mq_cnt_reg : mq_cnt_reg - CW'(1);
            end
            else
            begin
                sq_head_next = wrap_add(sq_head_reg, CW'(1));
                sq_cnt_next  = sq_cnt_reg - CW'(1);
                if (s_vis)
                begin
                    mq_cnt_next = mq_cnt_reg + CW'(1);
                end
            end
            if (s_vis)
            begin
                vis_next[q_rdata] = 1'b0;
                inm_next[q_rdata] = 1'b1;
            end
            else
            begin
                valid_next[q_rdata] = 1'b0;
                inm_next[q_rdata]   = 1'b0;
            end
        end

        // Ghost history.
        if (cmd.g_cmp && gvalid_reg[g_addr] && (g_rdata_reg == cmp_key_reg))
        begin
            gvalid_next[g_addr] = 1'b0;
            ghost_hit_next      = 1'b1;
        end
        if (cmd.g_pop)
        begin
            g_head_next = wrap_add(g_head_reg, CW'(1));
            g_cnt_next  = g_cnt_reg - CW'(1);
        end
        if (cmd.g_push)
        begin
            gvalid_next[g_tail] = 1'b1;
            g_cnt_next          = g_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            ghost_hit_reg <= 1'b0;
            sel_main_reg  <= 1'b0;
            valid_reg     <= '0;
            inm_reg       <= '0;
            vis_reg       <= '0;
            gvalid_reg    <= '0;
            sq_head_reg   <= '0;
            mq_head_reg   <= '0;
            g_head_reg    <= '0;
            sq_cnt_reg    <= '0;
            mq_cnt_reg    <= '0;
            g_cnt_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cap_we)
            begin
                cap_reg <= cap_wdata;
            end
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            ghost_hit_reg <= ghost_hit_next;
            sel_main_reg  <= sel_main_next;
            valid_reg     <= valid_next;
            inm_reg       <= inm_next;
            vis_reg       <= vis_next;
            gvalid_reg    <= gvalid_next;
            sq_head_reg   <= sq_head_next;
            mq_head_reg   <= mq_head_next;
            g_head_reg    <= g_head_next;
            sq_cnt_reg    <= sq_cnt_next;
            mq_cnt_reg    <= mq_cnt_next;
            g_cnt_reg     <= g_cnt_next;
            done_reg      <= cmd.done;
        end
    end

    // Small-queue threshold max(1, capacity/10) and ghost length.
    assign div_prod = (CAP_W+8)'(cap_reg) * (CAP_W+8)'(DIV10_MUL);

    always_comb
    begin
        thr = CMPW'(div_prod >> DIV10_SHIFT);
        if (thr == '0)
        begin
            thr = CMPW'(1);
        end
        glen = CMPW'(cap_reg);
        if (cap_reg == '0)
        begin
            glen = CMPW'(1);
        end
        else if (glen > ENT_CMP)
        begin
            glen = ENT_CMP;
        end
    end

    assign small_ge = (CMPW'(sq_cnt_reg) >= thr);

    // Status to the controller.
    always_comb
    begin
        sts.hit         = hit_reg;
        sts.free_found  = free_reg;
        sts.scan_last   = (idx_reg == CW'(ENTRIES - 1));
        sts.lk_match    = lk_match;
        sts.g_scan_end  = (idx_reg == g_cnt_reg);
        sts.q_scan_end  = (idx_reg == sel_cnt);
        sts.q_match     = (q_rdata == hit_idx_reg);
        sts.q_shift_end = (idx_plus >= (CW+1)'(sel_cnt));
        sts.ev_found    = !s_vis;
        sts.s_empty     = (sq_cnt_reg == '0);
        sts.m_empty     = (mq_cnt_reg == '0);
        sts.small_pick  = (sq_cnt_reg != '0) && ((mq_cnt_reg == '0) || small_ge);
        sts.sel_is_main = sel_main_reg;
        sts.g_trim      = (g_cnt_reg != '0) && (CMPW'(g_cnt_reg) >= glen);
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign evicted_key = evk_reg;
    assign in_main     = inm_out_reg;

endmodule

// File: rtl/core/s3fifo_replacement_policy.sv
// S3-FIFO replacement policy over a table of ENTRIES keyed slots.
// Command channel: drive operation and key with start high; the item is taken
// at a clock edge where start is high and busy is low. busy stays high until
// the item has finished. Each item gives exactly one result, shown on
// status, evicted_key and in_main for one cycle with done high; done is high
// in the first cycle in which busy is low again, and a new item may be
// started in that same cycle. An unknown operation gives its result in the
// cycle after it is taken. The receiver cannot stall: it must take the result
// in the cycle it is shown.
// Capacity is written with capacity_we and capacity; the user must write it
// only while the block is idle, as the block itself does not enforce it.
// Operations run as sequential walks over the entry key memory, the ghost
// memory and the queue memories:
//   lookup (insert, touch, query, remove): walks slots up to the hit, or all
//     ENTRIES slots on a miss, then dispatches; an insert miss with a free
//     slot and a remove then walk the ghost history, and that insert commits;
//     a remove that hits walks its queue up to the slot and compacts the rest.
//   evict: chooses a queue, visits elements up to and including the victim,
//     moves to main when small runs empty and fetches the victim key; a
//     small-queue victim adds a ghost walk, ages out old entries and appends.
// Reset empties the table, both queues and the ghost history at once and
// sets capacity to 64; no clearing pass is needed.
module s3fifo_replacement_policy
    import s3f_pkg::*;
#(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       operation,
    input  logic [KEY_W-1:0] key,
    output logic             busy,
    input  logic             capacity_we,
    input  logic [CAP_W-1:0] capacity,
    output logic             done,
    output logic [2:0]       status,
    output logic [KEY_W-1:0] evicted_key,
    output logic             in_main
);

    cmd_t cmd;
    sts_t sts;

    // Operation sequencer.
    s3f_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .sts       (sts),
        .busy      (busy),
        .cmd       (cmd)
    );

    // Table, queues, ghost history and result registers.
    s3f_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         (key),
        .cap_we      (capacity_we),
        .cap_wdata   (capacity),
        .cmd         (cmd),
        .sts         (sts),
        .done        (done),
        .status      (status),
        .evicted_key (evicted_key),
        .in_main     (in_main)
    );

endmodule
